// ===== hw/rtl/ntsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntsc_pkg: nested TSC scale composer shared types and constants
// Request and plan payload structs, status codes and fixed-point constants.
// ----------------------------------------------------------------------------
package ntsc_pkg;

  // fraction bits of the fixed-point multipliers (1..63)
  localparam int unsigned FRAC_BITS = 48;

  localparam logic [63:0] MULT_ONE = 64'd1 << FRAC_BITS;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef struct packed {
    logic [63:0] outer_offset;
    logic [63:0] outer_multiplier;
    logic        outer_scale_on;
    logic [63:0] inner_multiplier;
    logic        inner_scale_on;
    logic [63:0] inner_offset;
    logic        inner_offset_on;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] outer_plan_offset;
    logic [63:0] outer_plan_multiplier;
    logic        outer_plan_scale_on;
    logic [63:0] inner_plan_offset;
    logic [63:0] inner_plan_multiplier;
    logic        inner_plan_scale_on;
  } plan_t;

endpackage

// ===== hw/rtl/nested_tsc_scale_composer.sv =====
// ----------------------------------------------------------------------------
// nested_tsc_scale_composer: nested guest TSC offset/scaling composition
// Checks outer and inner guest TSC settings, composes the inner multiplier
// and scales the outer offset into the inner plan.
// ----------------------------------------------------------------------------
//
//  channel | handshake                | payload           | direction
//  --------+--------------------------+-------------------+----------
//  request | req_valid / req_stall    | req  (req_t)      | in
//  plan    | plan_valid / plan_stall  | plan (plan_t)     | out
//
// Six-stage pipeline: request register, setting checks, 32x32 partial
// products, 128-bit product sums, range check and offset sign, final add.
// One request per cycle while req_stall is low; each request passes through r0 to r5 in order, and r5 drives the plan.
// Reset clears the stage valid bits only.
// A stalled plan backs the pipe up stage by stage; empty stages still take
// new requests, so req_stall rises only when every stage is full.

module nested_tsc_scale_composer (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  ntsc_pkg::req_t  req,
  output logic            plan_valid,
  input  logic            plan_stall,
  output ntsc_pkg::plan_t plan
);

  localparam int unsigned NUM_STG = 6;
  localparam int unsigned LO_TOP  = ntsc_pkg::FRAC_BITS + 63;
  localparam int unsigned HI_BOT  = ntsc_pkg::FRAC_BITS + 64;

  typedef struct packed {
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } pp_t;

  typedef struct packed {
    logic        invalid;
    logic        o_on;
    logic        scale_on;
    logic        neg;
    logic [63:0] o_off;
    logic [63:0] o_eff;
    logic [63:0] i_eff;
    logic [63:0] mag;
    logic [63:0] i_add;
  } s1_t;

  typedef struct packed {
    logic        invalid;
    logic        o_on;
    logic        scale_on;
    logic        neg;
    logic [63:0] o_off;
    logic [63:0] o_eff;
    logic [63:0] i_add;
    pp_t         pc;
    pp_t         po;
  } s2_t;

  typedef struct packed {
    logic         invalid;
    logic         o_on;
    logic         scale_on;
    logic         neg;
    logic [63:0]  o_off;
    logic [63:0]  o_eff;
    logic [63:0]  i_add;
    logic [127:0] prod_c;
    logic [127:0] prod_o;
  } s3_t;

  typedef struct packed {
    ntsc_pkg::status_t status;
    logic              o_on;
    logic              scale_on;
    logic [63:0]       o_off;
    logic [63:0]       o_eff;
    logic [63:0]       c_lo;
    logic [63:0]       off_sc;
    logic [63:0]       i_add;
  } s4_t;

  function automatic pp_t part_mul(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.p00 = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
    r.p01 = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
    r.p10 = {32'd0, a[63:32]} * {32'd0, b[31:0]};
    r.p11 = {32'd0, a[63:32]} * {32'd0, b[63:32]};
    return r;
  endfunction

  function automatic logic [127:0] sum_pp(input pp_t p);
    return {p.p11, p.p00} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0};
  endfunction

  logic [NUM_STG-1:0] vld;
  logic [NUM_STG-1:0] adv;

  ntsc_pkg::req_t r0;
  s1_t            r1, r1_next;
  s2_t            r2, r2_next;
  s3_t            r3, r3_next;
  s4_t            r4, r4_next;
  ntsc_pkg::plan_t r5, r5_next;

  // a stage moves when empty or when the stage after it moves
  always_comb begin
    adv[NUM_STG-1] = !vld[NUM_STG-1] || !plan_stall;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign req_stall  = !adv[0];
  assign plan_valid = vld[NUM_STG-1];
  assign plan       = r5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) r0 <= req;
    if (adv[1]) r1 <= r1_next;
    if (adv[2]) r2 <= r2_next;
    if (adv[3]) r3 <= r3_next;
    if (adv[4]) r4 <= r4_next;
    if (adv[5]) r5 <= r5_next;
  end

  // setting checks, effective multipliers and outer offset magnitude
  always_comb begin
    r1_next.invalid =
        (!r0.outer_scale_on && r0.outer_multiplier != ntsc_pkg::MULT_ONE) ||
        (!r0.inner_scale_on && r0.inner_multiplier != ntsc_pkg::MULT_ONE) ||
        (!r0.inner_offset_on && r0.inner_offset != 64'd0) ||
        (r0.outer_scale_on && r0.outer_multiplier == 64'd0) ||
        (r0.inner_scale_on && r0.inner_multiplier == 64'd0);
    r1_next.o_on     = r0.outer_scale_on;
    r1_next.scale_on = r0.outer_scale_on || (r0.inner_scale_on && r0.inner_offset_on);
    r1_next.neg      = r0.outer_offset[63];
    r1_next.o_off    = r0.outer_offset;
    r1_next.o_eff    = r0.outer_scale_on ? r0.outer_multiplier : ntsc_pkg::MULT_ONE;
    r1_next.i_eff    = (r0.inner_scale_on && r0.inner_offset_on) ?
                       r0.inner_multiplier : ntsc_pkg::MULT_ONE;
    r1_next.mag      = r0.outer_offset[63] ? (64'd0 - r0.outer_offset) : r0.outer_offset;
    r1_next.i_add    = r0.inner_offset_on ? r0.inner_offset : 64'd0;
  end

  always_comb begin
    r2_next.invalid  = r1.invalid;
    r2_next.o_on     = r1.o_on;
    r2_next.scale_on = r1.scale_on;
    r2_next.neg      = r1.neg;
    r2_next.o_off    = r1.o_off;
    r2_next.o_eff    = r1.o_eff;
    r2_next.i_add    = r1.i_add;
    r2_next.pc       = part_mul(r1.o_eff, r1.i_eff);
    r2_next.po       = part_mul(r1.mag, r1.i_eff);
  end

  always_comb begin
    r3_next.invalid  = r2.invalid;
    r3_next.o_on     = r2.o_on;
    r3_next.scale_on = r2.scale_on;
    r3_next.neg      = r2.neg;
    r3_next.o_off    = r2.o_off;
    r3_next.o_eff    = r2.o_eff;
    r3_next.i_add    = r2.i_add;
    r3_next.prod_c   = sum_pp(r2.pc);
    r3_next.prod_o   = sum_pp(r2.po);
  end

  // composed multiplier range check; restore offset sign
  always_comb begin
    r4_next.c_lo = r3.prod_c[LO_TOP:ntsc_pkg::FRAC_BITS];
    if (r3.invalid) begin
      r4_next.status = ntsc_pkg::ST_INVALID;
    end else if (r3.prod_c[127:HI_BOT] != '0 || r4_next.c_lo == 64'd0) begin
      r4_next.status = ntsc_pkg::ST_RANGE;
    end else begin
      r4_next.status = ntsc_pkg::ST_OK;
    end
    r4_next.o_on     = r3.o_on;
    r4_next.scale_on = r3.scale_on;
    r4_next.o_off    = r3.o_off;
    r4_next.o_eff    = r3.o_eff;
    r4_next.off_sc   = r3.neg ? (64'd0 - r3.prod_o[LO_TOP:ntsc_pkg::FRAC_BITS]) :
                                r3.prod_o[LO_TOP:ntsc_pkg::FRAC_BITS];
    r4_next.i_add    = r3.i_add;
  end

  // on any error only the status survives
  always_comb begin
    r5_next        = '0;
    r5_next.status = r4.status;
    if (r4.status == ntsc_pkg::ST_OK) begin
      r5_next.outer_plan_offset     = r4.o_off;
      r5_next.outer_plan_multiplier = r4.o_eff;
      r5_next.outer_plan_scale_on   = r4.o_on;
      r5_next.inner_plan_offset     = r4.off_sc + r4.i_add;
      r5_next.inner_plan_multiplier = r4.c_lo;
      r5_next.inner_plan_scale_on   = r4.scale_on;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
      plan_valid && plan.status != ntsc_pkg::ST_OK |->
      plan.outer_plan_offset == 64'd0 && plan.outer_plan_multiplier == 64'd0 &&
      plan.inner_plan_offset == 64'd0 && plan.inner_plan_multiplier == 64'd0 &&
      !plan.outer_plan_scale_on && !plan.inner_plan_scale_on)
    else $error("error plan carries nonzero fields");

  a_ok_mult: assert property (@(posedge clk) disable iff (rst)
      plan_valid && plan.status == ntsc_pkg::ST_OK |->
      plan.inner_plan_multiplier != 64'd0)
    else $error("ok plan with zero composed multiplier");

  // with outer scaling off, the composed multiplier is the inner one, or one
  a_outer_one: assert property (@(posedge clk) disable iff (rst)
      plan_valid && plan.status == ntsc_pkg::ST_OK && !plan.outer_plan_scale_on |->
      (plan.outer_plan_multiplier == ntsc_pkg::MULT_ONE) &&
      (plan.inner_plan_scale_on || (plan.inner_plan_multiplier == ntsc_pkg::MULT_ONE)))
    else $error("unscaled outer plan with wrong multiplier");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
      req_stall |-> vld == '1)
    else $error("request stalled with an empty stage");

endmodule

// ===== tb/tb_nested_tsc_scale_composer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nested_tsc_scale_composer: self-checking bench for the TSC scale composer
// Directed corner requests, then mostly well-formed random settings with
// some broken ones, under random idle and stall bursts, a long plan hold-off
// and a full drain. Every plan is checked field by field against a local
// prediction of the composed outer and inner plans.
// ----------------------------------------------------------------------------
module tb_nested_tsc_scale_composer;

  localparam int unsigned CYCLE_LIMIT = 300000;

  class plan_checker;
    ntsc_pkg::plan_t expected_plans[$];
    int    errors;

    function new();
      errors = 0;
    endfunction

    function ntsc_pkg::plan_t compose_plan(ntsc_pkg::req_t r);
      ntsc_pkg::plan_t p;
      logic [63:0] o_eff;
      logic [63:0] i_eff;
      logic [63:0] mag;
      logic [63:0] scaled;
      logic [127:0] prod;
      logic [127:0] shifted;
      p = '0;
      if ((!r.outer_scale_on && r.outer_multiplier != ntsc_pkg::MULT_ONE) ||
          (!r.inner_scale_on && r.inner_multiplier != ntsc_pkg::MULT_ONE) ||
          (!r.inner_offset_on && r.inner_offset != 64'd0) ||
          (r.outer_scale_on && r.outer_multiplier == 64'd0) ||
          (r.inner_scale_on && r.inner_multiplier == 64'd0)) begin
        p.status = ntsc_pkg::ST_INVALID;
        return p;
      end
      o_eff = r.outer_scale_on ? r.outer_multiplier : ntsc_pkg::MULT_ONE;
      i_eff = (r.inner_scale_on && r.inner_offset_on) ?
              r.inner_multiplier : ntsc_pkg::MULT_ONE;
      prod = {64'd0, o_eff} * {64'd0, i_eff};
      shifted = prod >> ntsc_pkg::FRAC_BITS;
      if (shifted[127:64] != 64'd0 || shifted[63:0] == 64'd0) begin
        p.status = ntsc_pkg::ST_RANGE;
        return p;
      end
      // sign-magnitude scaling, fraction truncated toward zero
      mag = r.outer_offset[63] ? -r.outer_offset : r.outer_offset;
      prod = {64'd0, mag} * {64'd0, i_eff};
      scaled = prod[ntsc_pkg::FRAC_BITS +: 64];
      if (r.outer_offset[63]) scaled = -scaled;
      if (r.inner_offset_on) scaled = scaled + r.inner_offset;
      p.status                = ntsc_pkg::ST_OK;
      p.outer_plan_offset     = r.outer_offset;
      p.outer_plan_multiplier = o_eff;
      p.outer_plan_scale_on   = r.outer_scale_on;
      p.inner_plan_offset     = scaled;
      p.inner_plan_multiplier = shifted[63:0];
      p.inner_plan_scale_on   = r.outer_scale_on || (r.inner_scale_on && r.inner_offset_on);
      return p;
    endfunction

    function void note_request(ntsc_pkg::req_t r);
      expected_plans.push_back(compose_plan(r));
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_plan(ntsc_pkg::plan_t p);
      ntsc_pkg::plan_t e;
      if (expected_plans.size() == 0) begin
        $error("plan: unexpected result, status %0h", p.status);
        errors++;
        return;
      end
      e = expected_plans.pop_front();
      compare_field("status", 64'(e.status), 64'(p.status));
      compare_field("outer_plan_offset", e.outer_plan_offset, p.outer_plan_offset);
      compare_field("outer_plan_multiplier", e.outer_plan_multiplier,
                    p.outer_plan_multiplier);
      compare_field("outer_plan_scale_on", 64'(e.outer_plan_scale_on),
                    64'(p.outer_plan_scale_on));
      compare_field("inner_plan_offset", e.inner_plan_offset, p.inner_plan_offset);
      compare_field("inner_plan_multiplier", e.inner_plan_multiplier,
                    p.inner_plan_multiplier);
      compare_field("inner_plan_scale_on", 64'(e.inner_plan_scale_on),
                    64'(p.inner_plan_scale_on));
    endfunction

    function int pending();
      return expected_plans.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  ntsc_pkg::req_t  req = '0;
  logic  plan_valid;
  logic  plan_stall = 1'b0;
  ntsc_pkg::plan_t plan;

  plan_checker sb;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  bit          hold_plans = 1'b0;
  int unsigned cycles = 0;

  nested_tsc_scale_composer i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .plan_valid (plan_valid),
    .plan_stall (plan_stall),
    .plan       (plan)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) sb.note_request(req);
    if (!rst && plan_valid && !plan_stall) sb.check_plan(plan);
  end

  // plan side: random stall bursts, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_plans) begin
        hold_plans = 1'b0;
        plan_stall <= 1'b1;
        repeat (300) @(posedge clk);
        plan_stall <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        plan_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        plan_stall <= 1'b0;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_offset();
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(0, 1000));
      1: return -64'($urandom_range(1, 1000));
      2: return $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      default: return rand64();
    endcase
  endfunction

  function automatic logic [63:0] pick_mult();
    logic [63:0] m;
    case ($urandom_range(0, 3))
      0: m = rand64() >> $urandom_range(0, 63);
      1: m = ntsc_pkg::MULT_ONE;
      2: m = ntsc_pkg::MULT_ONE + 64'($urandom_range(0, 65535)) - 64'd32768;
      default: m = 64'd1 << $urandom_range(0, 63);
    endcase
    if (m == 64'd0) m = 64'd1;
    return m;
  endfunction

  function automatic ntsc_pkg::req_t random_request();
    ntsc_pkg::req_t r;
    r.outer_scale_on   = 1'($urandom_range(0, 1));
    r.outer_multiplier = r.outer_scale_on ? pick_mult() : ntsc_pkg::MULT_ONE;
    r.inner_scale_on   = 1'($urandom_range(0, 1));
    r.inner_multiplier = r.inner_scale_on ? pick_mult() : ntsc_pkg::MULT_ONE;
    r.inner_offset_on  = 1'($urandom_range(0, 1));
    r.inner_offset     = r.inner_offset_on ? pick_offset() : 64'd0;
    r.outer_offset     = pick_offset();
    // about one in eight requests carries a broken setting
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 4))
        0: begin
          r.outer_scale_on   = 1'b0;
          r.outer_multiplier = pick_mult();
        end
        1: begin
          r.inner_scale_on   = 1'b0;
          r.inner_multiplier = pick_mult();
        end
        2: begin
          r.inner_offset_on = 1'b0;
          r.inner_offset    = rand64() | 64'd1;
        end
        3: begin
          r.outer_scale_on   = 1'b1;
          r.outer_multiplier = 64'd0;
        end
        default: begin
          r.inner_scale_on   = 1'b1;
          r.inner_multiplier = 64'd0;
        end
      endcase
    end
    return r;
  endfunction

  function automatic ntsc_pkg::req_t mk(logic [63:0] o_off, logic [63:0] o_mul, logic o_on,
                                        logic [63:0] i_mul, logic i_on,
                                        logic [63:0] i_off, logic i_off_on);
    ntsc_pkg::req_t r;
    r.outer_offset     = o_off;
    r.outer_multiplier = o_mul;
    r.outer_scale_on   = o_on;
    r.inner_multiplier = i_mul;
    r.inner_scale_on   = i_on;
    r.inner_offset     = i_off;
    r.inner_offset_on  = i_off_on;
    return r;
  endfunction

  function automatic int pick_gap();
    if (!send_idle || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 19);
  endfunction

  // called right after a rising edge; returns right after the accepting edge, or after the gap edges that follow it
  task automatic send_request(input ntsc_pkg::req_t r, input int gap);
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_plans_done();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE = ntsc_pkg::MULT_ONE;
    ntsc_pkg::req_t d[$];
    // plain pass-through and offset extremes
    d.push_back(mk(64'd0, ONE, 1'b0, ONE, 1'b0, 64'd0, 1'b0));
    d.push_back(mk(ONES, ONE, 1'b0, ONE, 1'b0, 64'd0, 1'b0));
    d.push_back(mk(MIN_NEG, ONE, 1'b0, ONE * 3, 1'b1, 64'd5, 1'b1));
    d.push_back(mk(MAX_POS, ONE, 1'b0, ONE >> 1, 1'b1, ONES, 1'b1));
    d.push_back(mk(ONES, MIN_NEG, 1'b1, ONE, 1'b1, 64'd0, 1'b1));
    d.push_back(mk(MIN_NEG, ONE, 1'b0, ONES, 1'b1, ONES, 1'b1));
    d.push_back(mk(-64'd7, ONE, 1'b0, 64'd3 << 46, 1'b1, 64'd9, 1'b1));
    // inner scaling without inner offsetting: effective multiplier is one
    d.push_back(mk(64'd123, 64'd5 << 44, 1'b1, 64'd7 << 46, 1'b1, 64'd0, 1'b0));
    d.push_back(mk(64'd123, ONE, 1'b0, 64'd7 << 46, 1'b1, 64'd0, 1'b0));
    d.push_back(mk(ONES, ONE, 1'b1, ONE, 1'b0, ONES, 1'b1));
    // invalid settings
    d.push_back(mk(64'd1, ONE + 64'd1, 1'b0, ONE, 1'b0, 64'd0, 1'b0));
    d.push_back(mk(64'd1, ONE, 1'b0, 64'd0, 1'b0, 64'd0, 1'b0));
    d.push_back(mk(64'd1, ONE, 1'b0, ONE, 1'b0, 64'd1, 1'b0));
    d.push_back(mk(64'd1, 64'd0, 1'b1, ONE, 1'b0, 64'd0, 1'b0));
    d.push_back(mk(64'd1, ONE, 1'b0, 64'd0, 1'b1, 64'd0, 1'b1));
    d.push_back(mk(ONES, ONES, 1'b0, ONES, 1'b0, ONES, 1'b0));
    // composed multiplier range
    d.push_back(mk(64'd5, 64'd1, 1'b1, 64'd1, 1'b1, 64'd0, 1'b1));
    d.push_back(mk(64'd5, ONES, 1'b1, ONES, 1'b1, 64'd0, 1'b1));
    d.push_back(mk(64'd5, ONES, 1'b1, ONE, 1'b0, 64'd0, 1'b0));
    d.push_back(mk(64'd5, ONES, 1'b1, ONE + 64'd1, 1'b1, 64'd0, 1'b1));
    d.push_back(mk(64'd5, 64'd1, 1'b1, ONE, 1'b0, 64'd0, 1'b0));
    d.push_back(mk(ONES, ONES, 1'b1, ONES, 1'b1, ONES, 1'b1));
    foreach (d[k]) send_request(d[k], pick_gap());
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    for (int n = 0; n < 250; n++) begin
      if (n % 50 == 0) begin
        send_idle = $urandom_range(0, 3) != 0;
        recv_idle = $urandom_range(0, 3) != 0;
      end
      send_request(random_request(), pick_gap());
    end

    // long hold on the plan side while requests keep coming back to back
    hold_plans = 1'b1;
    for (int n = 0; n < 40; n++) send_request(random_request(), 0);
    wait_plans_done();
    @(posedge clk);

    send_idle = 1'b1;
    recv_idle = 1'b1;
    for (int n = 0; n < 200; n++) begin
      if (n % 50 == 0) begin
        send_idle = $urandom_range(0, 3) != 0;
        recv_idle = $urandom_range(0, 3) != 0;
      end
      send_request(random_request(), pick_gap());
    end

    // closing stretch at full rate on both sides
    send_idle = 1'b0;
    recv_idle = 1'b0;
    for (int n = 0; n < 160; n++) send_request(random_request(), 0);
    wait_plans_done();
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ntsc_pkg.sv
hw/rtl/nested_tsc_scale_composer.sv
tb/tb_nested_tsc_scale_composer.sv
